// File: rtl/sbfp_pkg.sv
// ----------------------------------------------------------------------------
// sbfp_pkg
// types, codes and constants shared by the seven-bit frame packer
// ----------------------------------------------------------------------------
package sbfp_pkg;

    localparam int PAYLOAD_W = 7;

    localparam logic [7:0] HIGH_BIT     = 8'h80;
    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // operation codes; six and seven are ignored
    typedef enum logic [2:0] {
        OP_BEGIN_QUERY  = 3'd0,
        OP_BEGIN_ANSWER = 3'd1,
        OP_HOST_BEGIN   = 3'd2,
        OP_APPEND       = 3'd3,
        OP_END          = 3'd4,
        OP_HOST_END     = 3'd5
    } sbfp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_APPEND,
        ST_FLUSH,
        ST_CRC,
        ST_NEWLINE
    } sbfp_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [5:0]  width;
        logic [6:0]  command;
        logic [3:0]  device_id;
    } sbfp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_done;
    } sbfp_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic emit_header;
        logic pack_step;
        logic emit_flush;
        logic emit_crc;
        logic emit_newline;
        logic last;
        logic done;
    } sbfp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic rem_zero;
        logic step_emits;
        logic step_last;
        logic rem_after_zero;
        logic used_nonzero;
    } sbfp_stat_t;

    // crc-8, poly 0x31, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/seven_bit_frame_packer_crc8.sv
// ----------------------------------------------------------------------------
// seven_bit_frame_packer_crc8
// builds serial command frames as a byte stream with 7-bit payloads and crc-8
// ----------------------------------------------------------------------------
//
//  channel  signals                      direction  carries
//  op       op_valid op_ready op_item    in         one operation item
//  tx       tx_valid tx_ready tx_item    out        one frame byte per item
//
//  an item is taken and then worked on alone; op_ready is high
//  only while the sequencer is idle
//  begin query / host begin: take the item, then emit the header byte
//  append of n bits: take it, then one pack step per cycle unless tx stalls,
//  each step filling the 7-bit payload; 32 bits need 5 to 6 steps
//  end: up to 3 bytes (flush, crc, newline for host end)
//  the single output register sets the pace: a step that emits a byte waits
//  while a byte is held and not taken, so tx stalls hold the sequencer
//  reset clears the payload, the bit count and presets the crc to 0xff
//
module seven_bit_frame_packer_crc8
    import sbfp_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_ready,
    input  sbfp_in_t  op_item,
    output logic      tx_valid,
    input  logic      tx_ready,
    output sbfp_out_t tx_item
);

    // controller to datapath commands and returned status
    sbfp_cmd_t  cmd;
    sbfp_stat_t stat;

    // sequencer
    sbfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .operation (op_item.operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    // packer, crc and output register
    sbfp_datapath #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .op_item  (op_item),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .tx_item  (tx_item)
    );

    // frame end always closes the run of bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_item.frame_done |-> tx_item.last_of_run)
        else $error("frame_done without last_of_run");

    // at most one byte source per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_header, cmd.pack_step, cmd.emit_flush,
                  cmd.emit_crc, cmd.emit_newline}))
        else $error("more than one byte source active");

    // a byte is never written over a held byte that is not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_header || cmd.emit_flush || cmd.emit_crc || cmd.emit_newline ||
         (cmd.pack_step && stat.step_emits)) |-> stat.out_free)
        else $error("output register overrun");

endmodule

// File: rtl/sbfp_ctrl.sv
// ----------------------------------------------------------------------------
// sbfp_ctrl
// sequencer for the frame packer: header, pack steps, flush, crc, newline
// ----------------------------------------------------------------------------
module sbfp_ctrl
    import sbfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_ready,
    input  logic [2:0] operation,
    input  sbfp_stat_t stat,
    output sbfp_cmd_t  cmd
);

    sbfp_state_t state_reg, state_next;
    logic        host_reg, host_next;
    logic        accept;

    assign op_ready = (state_reg == ST_IDLE);
    assign accept   = op_valid && op_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            host_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            host_reg  <= host_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        host_next  = host_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    host_next = (operation == OP_HOST_END);
                    if (operation == OP_BEGIN_QUERY || operation == OP_HOST_BEGIN)
                    begin
                        state_next = ST_HEADER;
                    end
                    else if (operation == OP_APPEND)
                    begin
                        state_next = ST_APPEND;
                    end
                    else if (operation == OP_END || operation == OP_HOST_END)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_HEADER:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_APPEND:
            begin
                if (stat.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if ((!stat.step_emits || stat.out_free) && stat.rem_after_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.used_nonzero || stat.out_free)
                begin
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                if (stat.out_free)
                begin
                    state_next = host_reg ? ST_NEWLINE : ST_IDLE;
                end
            end
            ST_NEWLINE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load  = 1'b1;
                    cmd.clear = (operation == OP_BEGIN_QUERY) ||
                                (operation == OP_BEGIN_ANSWER) ||
                                (operation == OP_HOST_BEGIN);
                end
            end
            ST_HEADER:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_header = 1'b1;
                    cmd.last        = 1'b1;
                end
            end
            ST_APPEND:
            begin
                if (!stat.rem_zero && (!stat.step_emits || stat.out_free))
                begin
                    cmd.pack_step = 1'b1;
                    cmd.last      = stat.step_last;
                end
            end
            ST_FLUSH:
            begin
                if (stat.used_nonzero && stat.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                end
            end
            ST_CRC:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_crc = 1'b1;
                    cmd.clear    = 1'b1;
                    cmd.last     = !host_reg;
                    cmd.done     = !host_reg;
                end
            end
            ST_NEWLINE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_newline = 1'b1;
                    cmd.last         = 1'b1;
                    cmd.done         = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/sbfp_datapath.sv
// ----------------------------------------------------------------------------
// sbfp_datapath
// field shifter, 7-bit payload packer, running crc and output register
// ----------------------------------------------------------------------------
module sbfp_datapath
    import sbfp_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sbfp_cmd_t  cmd,
    output sbfp_stat_t stat,
    input  sbfp_in_t   op_item,
    output logic       tx_valid,
    input  logic       tx_ready,
    output sbfp_out_t  tx_item
);

    localparam int SH_W  = MAX_FIELD_WIDTH;
    localparam int REM_W = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int CMP_W = (REM_W > 6) ? REM_W : 6;

    logic [PAYLOAD_W-1:0] partial_reg, partial_next;
    logic [2:0]           used_reg, used_next;
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           hdr_reg, hdr_next;
    logic [SH_W-1:0]      shreg_reg, shreg_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 out_valid_reg, out_valid_next;
    sbfp_out_t            out_reg, out_next;

    logic [CMP_W-1:0]     width_ext;
    logic [REM_W-1:0]     eff_width;
    logic [2:0]           space;
    logic [2:0]           take;
    logic [PAYLOAD_W-1:0] take_mask;
    logic [PAYLOAD_W-1:0] merged;
    logic [3:0]           used_sum;
    logic                 full;
    logic [REM_W-1:0]     rem_after;
    logic                 emit;
    logic [7:0]           emit_byte;
    logic                 emit_covered;

    // saturate the field width
    always_comb
    begin
        width_ext = CMP_W'(op_item.width);
        if (width_ext > CMP_W'(MAX_FIELD_WIDTH))
        begin
            eff_width = REM_W'(MAX_FIELD_WIDTH);
        end
        else
        begin
            eff_width = REM_W'(width_ext);
        end
    end

    // one pack step: fill the payload up to seven bits
    always_comb
    begin
        space = 3'd7 - used_reg;
        if (rem_reg >= REM_W'(space))
        begin
            take = space;
        end
        else
        begin
            take = rem_reg[2:0];
        end
        take_mask = 7'h7F >> (3'd7 - take);
        merged    = partial_reg | ((shreg_reg[PAYLOAD_W-1:0] & take_mask) << used_reg);
        used_sum  = 4'(used_reg) + 4'(take);
        full      = (used_sum == 4'd7);
        rem_after = rem_reg - REM_W'(take);
    end

    assign stat.out_free       = !out_valid_reg || tx_ready;
    assign stat.rem_zero       = (rem_reg == '0);
    assign stat.step_emits     = full;
    assign stat.step_last      = (rem_after < REM_W'(7));
    assign stat.rem_after_zero = (rem_after == '0);
    assign stat.used_nonzero   = (used_reg != 3'd0);

    // byte selection
    always_comb
    begin
        emit         = 1'b0;
        emit_byte    = 8'h00;
        emit_covered = 1'b0;
        priority if (cmd.emit_header)
        begin
            emit         = 1'b1;
            emit_byte    = hdr_reg;
            emit_covered = 1'b1;
        end
        else if (cmd.pack_step && full)
        begin
            emit         = 1'b1;
            emit_byte    = HIGH_BIT | {1'b0, merged};
            emit_covered = 1'b1;
        end
        else if (cmd.emit_flush)
        begin
            emit         = 1'b1;
            emit_byte    = HIGH_BIT | {1'b0, partial_reg};
            emit_covered = 1'b1;
        end
        else if (cmd.emit_crc)
        begin
            emit      = 1'b1;
            emit_byte = HIGH_BIT | crc_reg;
        end
        else if (cmd.emit_newline)
        begin
            emit      = 1'b1;
            emit_byte = NEWLINE_BYTE;
        end
    end

    // frame state
    always_comb
    begin
        partial_next = partial_reg;
        used_next    = used_reg;
        crc_next     = crc_reg;
        shreg_next   = shreg_reg;
        rem_next     = rem_reg;
        hdr_next     = hdr_reg;

        if (cmd.load)
        begin
            shreg_next = SH_W'(op_item.value);
            rem_next   = eff_width;
            if (op_item.operation == OP_BEGIN_QUERY)
            begin
                hdr_next = {1'b0, op_item.command[2:0], op_item.device_id};
            end
            else
            begin
                hdr_next = {1'b0, op_item.command};
            end
        end

        if (cmd.pack_step)
        begin
            shreg_next = shreg_reg >> take;
            rem_next   = rem_after;
            if (full)
            begin
                partial_next = '0;
                used_next    = 3'd0;
            end
            else
            begin
                partial_next = merged;
                used_next    = used_sum[2:0];
            end
        end

        if (emit && emit_covered)
        begin
            crc_next = crc8_update(crc_reg, emit_byte);
        end

        if (cmd.clear)
        begin
            partial_next = '0;
            used_next    = 3'd0;
            crc_next     = CRC_INIT;
        end
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = emit_byte;
            out_next.last_of_run = cmd.last;
            out_next.frame_done  = cmd.done;
        end
        else if (tx_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            used_reg      <= 3'd0;
            crc_reg       <= CRC_INIT;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            used_reg      <= used_next;
            crc_reg       <= crc_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg   <= hdr_next;
        shreg_reg <= shreg_next;
        out_reg   <= out_next;
    end

    assign tx_valid = out_valid_reg;
    assign tx_item  = out_reg;

endmodule
